[rtl/ssid_pkg.sv]
// Shared widths, command codes and controller/datapath handshake types.
package ssid_pkg;

   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned CMD_W       = 2;
   localparam int unsigned RCOUNT_W    = 6;
   localparam int unsigned MAX_RESULTS = 32;

   localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN         = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CMD_W-1:0]          command_type;
   typedef logic [RCOUNT_W-1:0]       rcount_type;

   typedef struct packed {
      logic load_first;
      logic load_second;
      logic walk_start;
      logic walk_step;
      logic emit_start;
      logic emit_put;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic walk_more;
      logic emit_last;
      logic rsp_free;
   } ctrl_status_type;

endpackage

[rtl/ssid_if.sv]
// Valid/ready channel interfaces for requests, results and the mode register.
interface ssid_req_if import ssid_pkg::*; ();
   logic        valid;
   logic        ready;
   command_type command;
   value_type   value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface ssid_rsp_if import ssid_pkg::*; ();
   logic       valid;
   logic       ready;
   value_type  element;
   rcount_type result_count;
   logic       is_last;
   logic       is_empty;
   logic       load_overflow;

   modport source (output valid, output element, output result_count, output is_last,
                   output is_empty, output load_overflow, input ready);
   modport sink   (input valid, input element, input result_count, input is_last,
                   input is_empty, input load_overflow, output ready);
endinterface

interface ssid_csr_if ();
   logic valid;
   logic ready;
   logic op_mode;

   modport source (output valid, output op_mode, input ready);
   modport sink   (input valid, input op_mode, output ready);
endinterface

[rtl/ssid_ctrl.sv]
// Sequencer for loads, the two-pointer walk and result emission.
module ssid_ctrl import ssid_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  command_type     req_command,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_WALK_RD  = 3'd1;
   localparam logic [2:0] ST_WALK_CMP = 3'd2;
   localparam logic [2:0] ST_EMIT_RD  = 3'd3;
   localparam logic [2:0] ST_EMIT_PUT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_command)
                  CMD_LOAD_FIRST:  cmd.load_first  = 1'b1;
                  CMD_LOAD_SECOND: cmd.load_second = 1'b1;
                  CMD_RUN: begin
                     cmd.walk_start = 1'b1;
                     state_in       = ST_WALK_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK_RD: state_in = ST_WALK_CMP;
         ST_WALK_CMP: begin
            if (status.walk_more) begin
               cmd.walk_step = 1'b1;
               state_in      = ST_WALK_RD;
            end else begin
               cmd.emit_start = 1'b1;
               state_in       = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: state_in = ST_EMIT_PUT;
         ST_EMIT_PUT: begin
            if (status.rsp_free) begin
               cmd.emit_put = 1'b1;
               if (status.emit_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/ssid_datapath.sv]
// Set stores, walk pointers, result buffer, mode register and result register.
module ssid_datapath import ssid_pkg::*; #(
   parameter int unsigned SET_DEPTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   input  logic            csr_valid,
   input  logic            csr_op_mode,
   input  value_type       req_value,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output value_type       rsp_element,
   output rcount_type      rsp_result_count,
   output logic            rsp_is_last,
   output logic            rsp_is_empty,
   output logic            rsp_load_overflow
);

   localparam int unsigned IW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int unsigned CW = $clog2(SET_DEPTH + 1);
   localparam int unsigned EMIT_MAX = (SET_DEPTH < MAX_RESULTS) ? SET_DEPTH : MAX_RESULTS;

   logic [VALUE_W-1:0] first_mem  [SET_DEPTH];
   logic [VALUE_W-1:0] second_mem [SET_DEPTH];
   logic [VALUE_W-1:0] walk_mem   [SET_DEPTH];

   logic [VALUE_W-1:0] first_rd_ff, second_rd_ff, walk_rd_ff;

   logic [CW-1:0] first_count_ff, first_count_in;
   logic [CW-1:0] second_count_ff, second_count_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, n_ff, n_in, k_ff, k_in;
   logic          overflow_ff, overflow_in;
   logic          mode_ff, mode_in;

   logic          rsp_valid_ff, rsp_valid_in;
   value_type     rsp_element_ff, rsp_element_in;
   rcount_type    rsp_count_ff, rsp_count_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_empty_ff, rsp_empty_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic                   first_full, second_full;
   logic                   j_done, lt, eq, hit;
   logic [CW-1:0]          k_next;
   logic [CW+RCOUNT_W-1:0] n_wide;

   assign first_full  = !(first_count_ff < CW'(SET_DEPTH));
   assign second_full = !(second_count_ff < CW'(SET_DEPTH));

   // Second set exhausted only reachable in difference mode: counts as a < b.
   assign j_done = !(j_ff < second_count_ff);
   assign lt     = j_done || ($signed(first_rd_ff) < $signed(second_rd_ff));
   assign eq     = !j_done && (first_rd_ff == second_rd_ff);
   assign hit    = mode_ff ? lt : eq;

   assign k_next = k_ff + CW'(1);
   assign n_wide = {{RCOUNT_W{1'b0}}, n_ff};

   assign status.walk_more = (i_ff < first_count_ff) && ((j_ff < second_count_ff) || mode_ff);
   assign status.emit_last = (n_ff == '0) || (k_next == n_ff) || (k_next == CW'(EMIT_MAX));
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      overflow_in     = overflow_ff;
      mode_in         = csr_valid ? csr_op_mode : mode_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      n_in            = n_ff;
      k_in            = k_ff;

      if (cmd.load_first) begin
         if (first_full) overflow_in = 1'b1;
         else first_count_in = first_count_ff + CW'(1);
      end
      if (cmd.load_second) begin
         if (second_full) overflow_in = 1'b1;
         else second_count_in = second_count_ff + CW'(1);
      end
      if (cmd.walk_start) begin
         i_in = '0;
         j_in = '0;
         n_in = '0;
      end
      if (cmd.walk_step) begin
         if (lt || eq) i_in = i_ff + CW'(1);
         if (!lt) j_in = j_ff + CW'(1);
         if (hit) n_in = n_ff + CW'(1);
      end
      if (cmd.emit_start) k_in = '0;
      if (cmd.emit_put) k_in = k_next;
      if (cmd.finish) begin
         first_count_in  = '0;
         second_count_in = '0;
         overflow_in     = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_element_in = rsp_element_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      if (cmd.emit_put) begin
         rsp_valid_in = 1'b1;
         rsp_ovf_in   = overflow_ff;
         rsp_count_in = n_wide[RCOUNT_W-1:0];
         rsp_last_in  = status.emit_last;
         if (n_ff == '0) begin
            rsp_element_in = '0;
            rsp_empty_in   = 1'b1;
         end else begin
            rsp_element_in = walk_rd_ff;
            rsp_empty_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_first && !first_full) first_mem[first_count_ff[IW-1:0]] <= req_value;
      if (cmd.load_second && !second_full) second_mem[second_count_ff[IW-1:0]] <= req_value;
      if (cmd.walk_step && hit) walk_mem[n_ff[IW-1:0]] <= first_rd_ff;
      first_rd_ff  <= first_mem[i_ff[IW-1:0]];
      second_rd_ff <= second_mem[j_ff[IW-1:0]];
      walk_rd_ff   <= walk_mem[k_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
         mode_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
         mode_ff         <= mode_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff           <= i_in;
      j_ff           <= j_in;
      n_ff           <= n_in;
      k_ff           <= k_in;
      rsp_element_ff <= rsp_element_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element       = rsp_element_ff;
   assign rsp_result_count  = rsp_count_ff;
   assign rsp_is_last       = rsp_last_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_load_overflow = rsp_ovf_ff;

endmodule

[rtl/sorted_set_intersect_difference.sv]
// Sorted-set intersection/difference engine: top level.
//
// req_ch carries one item per handshake: command 0 or 1 appends value to the first or
// second store, command 2 runs the walk, command 3 is ignored. Loads into a full store
// are dropped and flagged as load_overflow on the next run's results.
// csr_ch writes op_mode (0 intersection, 1 first minus second); write it while idle.
// rsp_ch returns the run's values in walk order, each with the total count and an
// is_last mark; an empty answer gives one item with is_empty set and element zero.
// A load or ignored command is accepted without leaving idle. A run performs walk steps
// (store read, then compare and pointer update), at most first+second count steps,
// then emits each result (result buffer read, then output register load).
// req_ch.ready is low from a run's acceptance until its last result is registered.
// A stalled rsp_ch holds the output register and pauses emission; nothing is lost.
// Reset clears both counts, the overflow flag and op_mode; store contents stay
// undefined until loaded. After a run both counts and the overflow flag return to zero.
module sorted_set_intersect_difference import ssid_pkg::*; #(
   parameter int unsigned SET_DEPTH = 32
) (
   input logic clock,
   input logic reset,
   ssid_req_if.sink   req_ch,
   ssid_rsp_if.source rsp_ch,
   ssid_csr_if.sink   csr_ch
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ch.ready = 1'b1;

   ssid_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .status      (status),
      .cmd         (cmd)
   );

   ssid_datapath #(
      .SET_DEPTH (SET_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_ch.valid),
      .csr_op_mode       (csr_ch.op_mode),
      .req_value         (req_ch.value),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_element       (rsp_ch.element),
      .rsp_result_count  (rsp_ch.result_count),
      .rsp_is_last       (rsp_ch.is_last),
      .rsp_is_empty      (rsp_ch.is_empty),
      .rsp_load_overflow (rsp_ch.load_overflow)
   );

endmodule

[rtl/ssid_checker.sv]
// Port-level checks on the result channel, bound to the top level.
module ssid_checker import ssid_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input value_type  rsp_element,
   input rcount_type rsp_result_count,
   input logic       rsp_is_last,
   input logic       rsp_is_empty,
   input logic       rsp_load_overflow
);

   // Output valid is cleared by reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result item dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_element) && $stable(rsp_result_count) &&
         $stable(rsp_is_last) && $stable(rsp_is_empty) && $stable(rsp_load_overflow))
      else $error("stalled result item changed");

   // An empty answer is a single, zeroed, final item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_is_last && rsp_result_count == '0 && rsp_element == '0)
      else $error("malformed empty result");

endmodule

bind sorted_set_intersect_difference ssid_checker u_ssid_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_element       (rsp_ch.element),
   .rsp_result_count  (rsp_ch.result_count),
   .rsp_is_last       (rsp_ch.is_last),
   .rsp_is_empty      (rsp_ch.is_empty),
   .rsp_load_overflow (rsp_ch.load_overflow)
);
